>>> rtl/pcm_pkg.sv
// Shared constants and types for the pixel color matrix.
package pcm_pkg;

  localparam int PIX_W              = 8;
  localparam int CFG_W              = 64;
  localparam int TERM_W             = 16;
  localparam int CFG_IDX_W          = 2;
  localparam int NUM_CHAN           = 3;
  localparam int GAIN_FRAC_BITS_DEF = 12;
  localparam int OFFSET_FRAC_BITS   = 4;

  localparam logic [PIX_W-1:0] CHAN_MAX = 8'd255;
  localparam logic [PIX_W-1:0] CHAN_MIN = 8'd0;

  localparam logic [CFG_W-1:0] RED_TERMS_RST   = 64'h0000_0000_0000_1000;
  localparam logic [CFG_W-1:0] GREEN_TERMS_RST = 64'h0000_0000_1000_0000;
  localparam logic [CFG_W-1:0] BLUE_TERMS_RST  = 64'h0000_1000_0000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RED_TERMS   = 2'd0,
    REG_GREEN_TERMS = 2'd1,
    REG_BLUE_TERMS  = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic signed [TERM_W-1:0] offset;
    logic signed [TERM_W-1:0] blue_gain;
    logic signed [TERM_W-1:0] green_gain;
    logic signed [TERM_W-1:0] red_gain;
  } terms_t;

endpackage

>>> rtl/pixel_color_matrix_top.sv
// Pixel color matrix: 3x3 gain matrix with offset, floor and clamp per pixel.
// Path from input beat to result beat: input register, then result register.
// Throughput: one pixel per cycle; on output backpressure the input stage stalls only while it holds a pixel.
// Each output color uses three 9x16 multipliers and a four-term add per cycle.
// Reset (rst_n low, synchronous): pipeline emptied, matrix set to identity, offsets zero.
module pixel_color_matrix_top import pcm_pkg::*; #(
  parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [PIX_W-1:0]     in_alpha_in,
  input  logic [PIX_W-1:0]     in_red_in,
  input  logic [PIX_W-1:0]     in_green_in,
  input  logic [PIX_W-1:0]     in_blue_in,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [PIX_W-1:0]     out_alpha_out,
  output logic [PIX_W-1:0]     out_red_out,
  output logic [PIX_W-1:0]     out_green_out,
  output logic [PIX_W-1:0]     out_blue_out,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int PROD_W    = PIX_W + 1 + TERM_W;
  localparam int OFF_SHIFT = GAIN_FRAC_BITS - OFFSET_FRAC_BITS;
  localparam int OFF_W     = TERM_W + OFF_SHIFT;
  localparam int ACC_W     = ((OFF_W > PROD_W) ? OFF_W : PROD_W) + 2;

  logic [CFG_W-1:0] terms_r [NUM_CHAN];

  logic             s1_valid_r;
  logic [PIX_W-1:0] s1_alpha_r;
  logic [PIX_W-1:0] s1_red_r;
  logic [PIX_W-1:0] s1_green_r;
  logic [PIX_W-1:0] s1_blue_r;

  logic             out_valid_r;
  logic [PIX_W-1:0] out_alpha_r;
  logic [PIX_W-1:0] chan_nxt [NUM_CHAN];
  logic [PIX_W-1:0] chan_r   [NUM_CHAN];

  logic s2_load;
  logic s1_load;

  assign s2_load  = !out_valid_r || out_ready;
  assign s1_load  = !s1_valid_r || s2_load;
  assign in_ready = s1_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      terms_r[0] <= RED_TERMS_RST;
      terms_r[1] <= GREEN_TERMS_RST;
      terms_r[2] <= BLUE_TERMS_RST;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_RED_TERMS:   terms_r[0] <= cfg_data;
        REG_GREEN_TERMS: terms_r[1] <= cfg_data;
        REG_BLUE_TERMS:  terms_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_load) begin
        s1_valid_r <= in_valid;
      end
      if (s2_load) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load && in_valid) begin
      s1_alpha_r <= in_alpha_in;
      s1_red_r   <= in_red_in;
      s1_green_r <= in_green_in;
      s1_blue_r  <= in_blue_in;
    end
    if (s2_load && s1_valid_r) begin
      out_alpha_r <= s1_alpha_r;
      for (int c = 0; c < NUM_CHAN; c++) begin
        chan_r[c] <= chan_nxt[c];
      end
    end
  end

  for (genvar c = 0; c < NUM_CHAN; c++) begin : g_chan
    terms_t                   t;
    logic signed [PROD_W-1:0] p_red;
    logic signed [PROD_W-1:0] p_green;
    logic signed [PROD_W-1:0] p_blue;
    logic signed [ACC_W-1:0]  off_ext;
    logic signed [ACC_W-1:0]  acc;

    assign t       = terms_t'(terms_r[c]);
    assign p_red   = $signed({1'b0, s1_red_r})   * t.red_gain;
    assign p_green = $signed({1'b0, s1_green_r}) * t.green_gain;
    assign p_blue  = $signed({1'b0, s1_blue_r})  * t.blue_gain;
    assign off_ext = ACC_W'(t.offset) <<< OFF_SHIFT;
    assign acc     = ACC_W'(p_red) + ACC_W'(p_green) + ACC_W'(p_blue) + off_ext;

    always_comb begin
      priority if (acc[ACC_W-1]) begin
        chan_nxt[c] = CHAN_MIN;
      end else if (|acc[ACC_W-2:GAIN_FRAC_BITS+PIX_W]) begin
        chan_nxt[c] = CHAN_MAX;
      end else begin
        chan_nxt[c] = acc[GAIN_FRAC_BITS+PIX_W-1:GAIN_FRAC_BITS];
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_alpha_out = out_alpha_r;
  assign out_red_out   = chan_r[0];
  assign out_green_out = chan_r[1];
  assign out_blue_out  = chan_r[2];

endmodule

>>> tb/tb_pixel_color_matrix_top.sv
// Testbench for pixel_color_matrix_top: random and corner pixels checked against a matrix predictor.
module tb_pixel_color_matrix_top import pcm_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [PIX_W-1:0] alpha;
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
  } pixel_t;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int RESET_CYCLES = 12;
  localparam int RAND_PHASES  = 6;
  localparam int PHASE_BEATS  = 165;
  localparam int HOLD_AT_BEAT = 400;
  localparam int HOLD_CYCLES  = 250;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 10;
  localparam int GAIN_SPAN    = 16'h1800;
  localparam int OFFSET_SPAN  = 16'h0C00;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [PIX_W-1:0]     in_alpha_in = '0;
  logic [PIX_W-1:0]     in_red_in = '0;
  logic [PIX_W-1:0]     in_green_in = '0;
  logic [PIX_W-1:0]     in_blue_in = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [PIX_W-1:0]     out_alpha_out;
  logic [PIX_W-1:0]     out_red_out;
  logic [PIX_W-1:0]     out_green_out;
  logic [PIX_W-1:0]     out_blue_out;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  pixel_t pending_pixels[$];
  pixel_t expected_pixels[$];
  terms_t channel_terms[NUM_CHAN];
  int     idle_pct = 8;
  int     err_cnt = 0;
  int     stall_cycles = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  pixel_color_matrix_top u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_alpha_in  (in_alpha_in),
    .in_red_in    (in_red_in),
    .in_green_in  (in_green_in),
    .in_blue_in   (in_blue_in),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_alpha_out(out_alpha_out),
    .out_red_out  (out_red_out),
    .out_green_out(out_green_out),
    .out_blue_out (out_blue_out),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  function automatic logic [PIX_W-1:0] matrix_channel(terms_t t, pixel_t p);
    longint acc;
    longint whole;
    acc = longint'(p.red) * longint'($signed(t.red_gain))
        + longint'(p.green) * longint'($signed(t.green_gain))
        + longint'(p.blue) * longint'($signed(t.blue_gain))
        + (longint'($signed(t.offset)) <<< (GAIN_FRAC_BITS_DEF - OFFSET_FRAC_BITS));
    if (acc < 0) return CHAN_MIN;
    whole = acc >>> GAIN_FRAC_BITS_DEF;
    if (whole > longint'(CHAN_MAX)) return CHAN_MAX;
    return PIX_W'(whole);
  endfunction

  function automatic pixel_t apply_matrix(pixel_t p);
    pixel_t r;
    r.alpha = p.alpha;
    r.red   = matrix_channel(channel_terms[REG_RED_TERMS], p);
    r.green = matrix_channel(channel_terms[REG_GREEN_TERMS], p);
    r.blue  = matrix_channel(channel_terms[REG_BLUE_TERMS], p);
    return r;
  endfunction

  function automatic logic [TERM_W-1:0] rand_term(int span);
    if ($urandom_range(0, 3) == 0) return TERM_W'($urandom);
    return TERM_W'($urandom_range(0, 2 * span) - span);
  endfunction

  function automatic logic [CFG_W-1:0] rand_terms();
    return {rand_term(OFFSET_SPAN), rand_term(GAIN_SPAN), rand_term(GAIN_SPAN),
            rand_term(GAIN_SPAN)};
  endfunction

  task automatic write_terms(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    if (idx < NUM_CHAN) channel_terms[idx] = terms_t'(val);
  endtask

  task automatic load_matrix(input logic [CFG_W-1:0] red_t, input logic [CFG_W-1:0] green_t,
                             input logic [CFG_W-1:0] blue_t);
    write_terms(REG_RED_TERMS, red_t);
    write_terms(REG_GREEN_TERMS, green_t);
    write_terms(REG_BLUE_TERMS, blue_t);
    write_terms(REG_UNUSED, {$urandom, $urandom});
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    while (pending_pixels.size() != 0 || in_valid || expected_pixels.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic send_corners();
    pixel_t corners[7];
    corners = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hAA55_AA55, 32'h55AA_55AA,
                32'h12FF_0000, 32'h3400_FF00, 32'h5600_00FF};
    foreach (corners[i]) pending_pixels.push_back(corners[i]);
  endtask

  task automatic compare_byte(input string name, input logic [PIX_W-1:0] want,
                              input logic [PIX_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      err_cnt++;
    end
  endtask

  // driver: advance to the next pixel when the current beat is taken
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready)
        expected_pixels.push_back(apply_matrix({in_alpha_in, in_red_in, in_green_in,
                                                in_blue_in}));
      if (!in_valid || in_ready) begin
        if (pending_pixels.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
          in_valid <= 1'b1;
          {in_alpha_in, in_red_in, in_green_in, in_blue_in} <= pending_pixels.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: check each result beat, hold off once for a long stretch
  always @(posedge clk) begin
    static int out_beats = 0;
    static int hold_left = 0;
    static bit hold_done = 1'b0;
    pixel_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_beats++;
        if (expected_pixels.size() == 0) begin
          $display("%0t: unexpected beat, expected none, actual %h", $time,
                   {out_alpha_out, out_red_out, out_green_out, out_blue_out});
          err_cnt++;
        end else begin
          want = expected_pixels.pop_front();
          compare_byte("alpha_out", want.alpha, out_alpha_out);
          compare_byte("red_out", want.red, out_red_out);
          compare_byte("green_out", want.green, out_green_out);
          compare_byte("blue_out", want.blue, out_blue_out);
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (!hold_done && out_beats >= HOLD_AT_BEAT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("tb_pixel_color_matrix_top: errors");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin
    channel_terms[REG_RED_TERMS]   = RED_TERMS_RST;
    channel_terms[REG_GREEN_TERMS] = GREEN_TERMS_RST;
    channel_terms[REG_BLUE_TERMS]  = BLUE_TERMS_RST;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_corners();
    drain();

    // overflow on red, negative sums on green, small negative fraction on blue
    load_matrix(64'h0000_2000_2000_2000, 64'h0010_F000_F000_F000, 64'hFFFF_0000_0000_0000);
    send_corners();
    drain();

    load_matrix(64'h7FFF_7FFF_7FFF_7FFF, 64'h8000_8000_8000_8000, 64'hFFFF_FFFF_FFFF_FFFF);
    send_corners();
    drain();

    for (int phase = 0; phase < RAND_PHASES; phase++) begin
      idle_pct = (phase == 2) ? 0 : 8;
      load_matrix(rand_terms(), rand_terms(), rand_terms());
      repeat (PHASE_BEATS) pending_pixels.push_back(pixel_t'($urandom));
      drain();
    end

    load_matrix(RED_TERMS_RST, GREEN_TERMS_RST, BLUE_TERMS_RST);
    send_corners();
    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (expected_pixels.size() != 0) begin
      $display("%0t: %0d results missing, expected %h, actual none", $time,
               expected_pixels.size(), expected_pixels[0]);
      err_cnt++;
    end
    if (err_cnt == 0) begin
      $display("tb_pixel_color_matrix_top: clean");
    end else begin
      $display("tb_pixel_color_matrix_top: errors");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/pcm_pkg.sv
rtl/pixel_color_matrix_top.sv
tb/tb_pixel_color_matrix_top.sv
